// ----- rtl/core/direct_mapped_cache_tag_checker_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the tag checker
// Clocked implication checks with an asynchronous active-low reset guard.
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_CACHE_TAG_CHECKER_CORE_ASSERT_SVH
`define DIRECT_MAPPED_CACHE_TAG_CHECKER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define DMC_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("dmc_checker: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define DMC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("dmc_checker: next-cycle check failed");

`endif

// ----- rtl/core/dmc_pkg.sv -----
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types, constants and helpers of the direct-mapped tag checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmc_pkg;

    localparam int ADDR_W = 32;
    localparam int CNT_W  = 32;

    typedef logic [CNT_W-1:0] count_t;

    localparam count_t CNT_MAX = '1;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_e;

    // Tag width for a given set count and line-number width. A non
    // power-of-two set count leaves one extra quotient bit.
    function automatic int tag_width(input int set_count, input int line_w);
        int k;
        k = $clog2(set_count);
        if ((1 << k) == set_count)
        begin
            return line_w - k;
        end
        return line_w - k + 1;
    endfunction

    function automatic count_t sat_inc(input count_t v);
        return (v == CNT_MAX) ? v : v + count_t'(1);
    endfunction

endpackage

// ----- rtl/core/dmc_access_if.sv -----
// ----------------------------------------------------------------------------
// dmc_access_if
// Access channel: one memory access (kind and byte address) per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dmc_access_if;
    import dmc_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output operation, output address, input ready);
    modport sink   (input valid, input operation, input address, output ready);
endinterface

// ----- rtl/core/dmc_result_if.sv -----
// ----------------------------------------------------------------------------
// dmc_result_if
// Result channel: hit flag and the four running access counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dmc_result_if;
    import dmc_pkg::*;

    logic   valid;
    logic   ready;
    logic   hit;
    count_t reads_seen;
    count_t read_hits_seen;
    count_t writes_seen;
    count_t write_hits_seen;

    modport source (
        output valid, output hit, output reads_seen, output read_hits_seen,
        output writes_seen, output write_hits_seen, input ready
    );
    modport sink (
        input valid, input hit, input reads_seen, input read_hits_seen,
        input writes_seen, input write_hits_seen, output ready
    );
endinterface

// ----- rtl/core/dmc_index.sv -----
// ----------------------------------------------------------------------------
// dmc_index
// Splits a line number into set index (line mod SET_COUNT) and tag
// (line div SET_COUNT). Power-of-two: bit slice. Otherwise: two-stage
// reciprocal multiply, then remainder by multiply and subtract.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmc_index #(
    parameter int SET_COUNT   = 256,
    parameter int OFFSET_BITS = 6
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic                                       in_op,
    input  logic [dmc_pkg::ADDR_W-OFFSET_BITS-1:0]     in_line,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic                                       out_op,
    output logic [$clog2(SET_COUNT)-1:0]               out_set,
    output logic [dmc_pkg::tag_width(SET_COUNT,
                  dmc_pkg::ADDR_W-OFFSET_BITS)-1:0]    out_tag
);
    import dmc_pkg::*;

    localparam int LINE_W = ADDR_W - OFFSET_BITS;
    localparam int SET_W  = $clog2(SET_COUNT);
    localparam int TAG_W  = tag_width(SET_COUNT, LINE_W);
    localparam bit POW2   = ((1 << SET_W) == SET_COUNT);

    generate
        if (POW2)
        begin : g_pow2
            assign in_ready  = out_ready;
            assign out_valid = in_valid;
            assign out_op    = in_op;
            assign out_set   = in_line[SET_W-1:0];
            assign out_tag   = in_line[LINE_W-1:SET_W];
        end
        else
        begin : g_recip
            localparam int PROD_W = 2 * LINE_W + 1;
            // ceil(2^(LINE_W+SET_W) / SET_COUNT), exact for every line number
            localparam logic [63:0] MAGIC_FULL =
                ((64'd1 << (LINE_W + SET_W)) + 64'(SET_COUNT) - 64'd1) / 64'(SET_COUNT);
            localparam logic [LINE_W:0]   MAGIC = MAGIC_FULL[LINE_W:0];
            localparam logic [LINE_W-1:0] DIVISOR = LINE_W'(SET_COUNT);

            logic              s1_vld_reg;
            logic              s1_op_reg;
            logic [LINE_W-1:0] s1_line_reg;
            logic [TAG_W-1:0]  s1_q_reg;
            logic              s2_vld_reg;
            logic              s2_op_reg;
            logic [SET_W-1:0]  s2_set_reg;
            logic [TAG_W-1:0]  s2_tag_reg;
            logic [PROD_W-1:0] prod;
            logic [LINE_W-1:0] q_times_d;
            logic [LINE_W-1:0] rem;
            logic              s1_take;
            logic              s2_take;

            assign s2_take  = !s2_vld_reg || out_ready;
            assign s1_take  = !s1_vld_reg || s2_take;
            assign in_ready = s1_take;

            assign prod      = PROD_W'(in_line) * PROD_W'(MAGIC);
            assign q_times_d = LINE_W'(s1_q_reg) * DIVISOR;
            assign rem       = s1_line_reg - q_times_d;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    s1_vld_reg <= 1'b0;
                    s2_vld_reg <= 1'b0;
                end
                else
                begin
                    if (s1_take)
                    begin
                        s1_vld_reg <= in_valid;
                    end
                    if (s2_take)
                    begin
                        s2_vld_reg <= s1_vld_reg;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (s1_take && in_valid)
                begin
                    s1_op_reg   <= in_op;
                    s1_line_reg <= in_line;
                    s1_q_reg    <= prod[LINE_W+SET_W +: TAG_W];
                end
                if (s2_take && s1_vld_reg)
                begin
                    s2_op_reg  <= s1_op_reg;
                    s2_set_reg <= rem[SET_W-1:0];
                    s2_tag_reg <= s1_q_reg;
                end
            end

            assign out_valid = s2_vld_reg;
            assign out_op    = s2_op_reg;
            assign out_set   = s2_set_reg;
            assign out_tag   = s2_tag_reg;
        end
    endgenerate

endmodule

// ----- rtl/core/dmc_tag_store.sv -----
// ----------------------------------------------------------------------------
// dmc_tag_store
// Tag memory, one {valid, tag} word per set, registered read.
// Clears itself after reset; forwards a write that lands in the cycle of
// a read to the same set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmc_tag_store #(
    parameter int SET_COUNT = 256,
    parameter int TAG_W     = 18
) (
    input  logic                         clk,
    input  logic                         rst_n,
    output logic                         busy,
    input  logic                         rd_en,
    input  logic [$clog2(SET_COUNT)-1:0] rd_set,
    input  logic [TAG_W-1:0]             cmp_tag,
    output logic                         hit,
    input  logic                         wr_en,
    input  logic [$clog2(SET_COUNT)-1:0] wr_set,
    input  logic [TAG_W-1:0]             wr_tag
);
    localparam int SET_W = $clog2(SET_COUNT);
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(SET_COUNT - 1);

    logic [TAG_W:0]     mem [SET_COUNT];
    logic [TAG_W:0]     rdata_reg;
    logic               busy_reg;
    logic [SET_W-1:0]   clr_idx_reg;
    logic               fwd_sel_reg;
    logic [TAG_W-1:0]   fwd_tag_reg;
    logic               mem_we;
    logic [SET_W-1:0]   mem_waddr;
    logic [TAG_W:0]     mem_wdata;

    assign busy = busy_reg;

    always_comb
    begin
        if (busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = wr_set;
            mem_wdata = {1'b1, wr_tag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_idx_reg <= '0;
            fwd_sel_reg <= 1'b0;
        end
        else
        begin
            if (busy_reg)
            begin
                if (clr_idx_reg == LAST_SET)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    clr_idx_reg <= clr_idx_reg + SET_W'(1);
                end
            end
            if (rd_en)
            begin
                fwd_sel_reg <= wr_en && (wr_set == rd_set);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg   <= mem[rd_set];
            fwd_tag_reg <= wr_tag;
        end
    end

    // memory returns the old word on a same-cycle write; forward instead
    assign hit = fwd_sel_reg ? (fwd_tag_reg == cmp_tag)
                             : (rdata_reg[TAG_W] && (rdata_reg[TAG_W-1:0] == cmp_tag));

endmodule

// ----- rtl/core/direct_mapped_cache_tag_checker_core.sv -----
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_checker_core
// Direct-mapped cache hit/miss checker with saturating access counters.
// ----------------------------------------------------------------------------
// Usage:
//   access (sink): one item per memory access, operation (0 read, 1 write)
//     and a 32-bit byte address. Line = address >> OFFSET_BITS, set =
//     line mod SET_COUNT, tag = line div SET_COUNT.
//   result (source): one item per access: hit flag plus the read, read-hit,
//     write and write-hit counts including this access, saturating at max.
//   A miss, read or write, allocates: the set becomes valid with the tag.
// Pipeline: split stages (non-power-of-two SET_COUNT only), compare, result.
// Throughput: one item per cycle while results are taken; the single tag
//   memory does one read and one write per cycle, a back-to-back access
//   to the same set is forwarded.
// Reset: counters clear; the tag memory is swept clear, one set per cycle,
//   with access.ready held low during the sweep.
// Stall: a result holds until taken; the compare stage and the split
//   stages still take items until each is occupied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module direct_mapped_cache_tag_checker_core #(
    parameter int SET_COUNT   = 256,
    parameter int OFFSET_BITS = 6
) (
    input  logic         clk,
    input  logic         rst_n,
    dmc_access_if.sink   access,
    dmc_result_if.source result
);
    import dmc_pkg::*;

    localparam int LINE_W = ADDR_W - OFFSET_BITS;
    localparam int SET_W  = $clog2(SET_COUNT);
    localparam int TAG_W  = tag_width(SET_COUNT, LINE_W);

    // split stage outputs
    logic               busy;
    logic               idx_in_valid;
    logic               idx_in_ready;
    logic               idx_out_valid;
    logic               idx_out_op;
    logic [SET_W-1:0]   idx_out_set;
    logic [TAG_W-1:0]   idx_out_tag;

    // compare stage: memory data for this item arrives while it sits here
    logic               r_vld_reg;
    logic               r_op_reg;
    logic [SET_W-1:0]   r_set_reg;
    logic [TAG_W-1:0]   r_tag_reg;

    logic               out_vld_reg;
    logic               hit_reg;
    count_t             reads_reg;
    count_t             read_hits_reg;
    count_t             writes_reg;
    count_t             write_hits_reg;
    count_t             reads_next;
    count_t             read_hits_next;
    count_t             writes_next;
    count_t             write_hits_next;

    logic               out_free;
    logic               r_take;
    logic               rd_en;
    logic               wr_en;
    logic               lookup_hit;
    logic               retire;

    // no access taken during the post-reset clearing sweep
    assign idx_in_valid = access.valid && !busy;
    assign access.ready = idx_in_ready && !busy;

    dmc_index #(
        .SET_COUNT   (SET_COUNT),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_index (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (idx_in_valid),
        .in_ready  (idx_in_ready),
        .in_op     (access.operation),
        .in_line   (access.address[ADDR_W-1:OFFSET_BITS]),
        .out_valid (idx_out_valid),
        .out_ready (r_take),
        .out_op    (idx_out_op),
        .out_set   (idx_out_set),
        .out_tag   (idx_out_tag)
    );

    assign out_free = !out_vld_reg || result.ready;
    assign r_take   = !r_vld_reg || out_free;
    assign retire   = r_vld_reg && out_free;
    // read issued as the item enters the compare stage
    assign rd_en    = idx_out_valid && r_take;
    // allocate on miss as the item leaves the compare stage
    assign wr_en    = retire && !lookup_hit;

    dmc_tag_store #(
        .SET_COUNT (SET_COUNT),
        .TAG_W     (TAG_W)
    ) u_tag_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .busy    (busy),
        .rd_en   (rd_en),
        .rd_set  (idx_out_set),
        .cmp_tag (r_tag_reg),
        .hit     (lookup_hit),
        .wr_en   (wr_en),
        .wr_set  (r_set_reg),
        .wr_tag  (r_tag_reg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_vld_reg <= 1'b0;
        end
        else if (r_take)
        begin
            r_vld_reg <= idx_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            r_op_reg  <= idx_out_op;
            r_set_reg <= idx_out_set;
            r_tag_reg <= idx_out_tag;
        end
    end

    always_comb
    begin
        reads_next      = reads_reg;
        read_hits_next  = read_hits_reg;
        writes_next     = writes_reg;
        write_hits_next = write_hits_reg;
        if (r_op_reg == OP_WRITE)
        begin
            writes_next = sat_inc(writes_reg);
            if (lookup_hit)
            begin
                write_hits_next = sat_inc(write_hits_reg);
            end
        end
        else
        begin
            reads_next = sat_inc(reads_reg);
            if (lookup_hit)
            begin
                read_hits_next = sat_inc(read_hits_reg);
            end
        end
    end

    // counters double as the result payload: they move only with a new result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            reads_reg      <= '0;
            read_hits_reg  <= '0;
            writes_reg     <= '0;
            write_hits_reg <= '0;
        end
        else if (retire)
        begin
            out_vld_reg    <= 1'b1;
            hit_reg        <= lookup_hit;
            reads_reg      <= reads_next;
            read_hits_reg  <= read_hits_next;
            writes_reg     <= writes_next;
            write_hits_reg <= write_hits_next;
        end
        else if (result.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    assign result.valid           = out_vld_reg;
    assign result.hit             = hit_reg;
    assign result.reads_seen      = reads_reg;
    assign result.read_hits_seen  = read_hits_reg;
    assign result.writes_seen     = writes_reg;
    assign result.write_hits_seen = write_hits_reg;

endmodule

// ----- rtl/core/dmc_checker.sv -----
// ----------------------------------------------------------------------------
// dmc_checker
// Port-level checks on the result channel of the tag checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "direct_mapped_cache_tag_checker_core_assert.svh"

module dmc_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  hit,
    input logic [31:0]           rd_cnt,
    input logic [31:0]           rd_hit_cnt,
    input logic [31:0]           wr_cnt,
    input logic [31:0]           wr_hit_cnt
);

    `DMC_ASSERT_NEXT(a_valid_holds, clk, rst_n, out_valid && !out_ready, out_valid)

    `DMC_ASSERT_NEXT(a_payload_holds, clk, rst_n, out_valid && !out_ready,
        $stable(hit) && $stable(rd_cnt) && $stable(rd_hit_cnt) &&
        $stable(wr_cnt) && $stable(wr_hit_cnt))

    // hit counts never pass their access counts
    `DMC_ASSERT_SAME(a_hits_bounded, clk, rst_n, out_valid,
        (rd_hit_cnt <= rd_cnt) && (wr_hit_cnt <= wr_cnt))

    // counters only grow
    `DMC_ASSERT_NEXT(a_counts_grow, clk, rst_n, 1'b1,
        (rd_cnt >= $past(rd_cnt)) && (rd_hit_cnt >= $past(rd_hit_cnt)) &&
        (wr_cnt >= $past(wr_cnt)) && (wr_hit_cnt >= $past(wr_hit_cnt)))

endmodule

bind direct_mapped_cache_tag_checker_core dmc_checker u_dmc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .hit        (result.hit),
    .rd_cnt     (result.reads_seen),
    .rd_hit_cnt (result.read_hits_seen),
    .wr_cnt     (result.writes_seen),
    .wr_hit_cnt (result.write_hits_seen)
);

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the direct-mapped tag checker: drives access items,
// predicts hit flag and counters per access, checks every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import dmc_pkg::*;

    // Geometry of the default build: 64-byte lines, 256 sets, 18-bit tags.
    localparam int OFFSET_BITS = 6;
    localparam int SET_BITS    = 8;
    localparam int SETS        = 1 << SET_BITS;
    localparam int TAG_BITS    = ADDR_W - OFFSET_BITS - SET_BITS;

    localparam int PROBE_COUNT  = 21;
    localparam int RANDOM_ITEMS = 1430;
    localparam int IDLE_PCT     = 30;
    // Window with no idling on either side.
    localparam int STEADY_FIRST = 500;
    localparam int STEADY_LAST  = 700;
    // Long receiver hold-offs, started at these result counts.
    localparam int HOLD_AT_A    = 120;
    localparam int HOLD_AT_B    = 900;
    localparam int HOLD_CYCLES  = 80;
    // The reset sweep holds ready low; leave plenty on top of it.
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic   hit;
        count_t reads_seen;
        count_t read_hits_seen;
        count_t writes_seen;
        count_t write_hits_seen;
    } access_outcome_t;

    // One row of the directed part. Where pinned is set, the hit flag is
    // typed in and overrides the prediction.
    typedef struct packed {
        op_e         op;
        logic [31:0] addr;
        logic        pinned;
        logic        hit;
    } probe_row_t;

    logic clk = 1'b0;
    logic rst_n;

    dmc_access_if access_ch ();
    dmc_result_if result_ch ();

    direct_mapped_cache_tag_checker_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .access (access_ch.sink),
        .result (result_ch.source)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Cache shadow: valid bits, tags and the four running counters
    // ------------------------------------------------------------------
    bit                  line_valid [SETS] = '{default: 1'b0};
    logic [TAG_BITS-1:0] line_tag   [SETS] = '{default: '0};
    count_t              read_total      = '0;
    count_t              read_hit_total  = '0;
    count_t              write_total     = '0;
    count_t              write_hit_total = '0;

    access_outcome_t pending_outcomes [$];

    int unsigned items_sent     = 0;
    int unsigned outcomes_taken = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    logic        hold_on        = 1'b0;

    // Recently accepted addresses, reused so that lines come back and hit.
    logic [31:0] recent_addr [8];
    int unsigned recent_ptr = 0;

    // Counters stop at all ones. With 32-bit counters that value is far
    // beyond any run length here, so only the increment path is exercised.
    function automatic count_t saturating_bump(input count_t v);
        return (v == CNT_MAX) ? v : v + count_t'(1);
    endfunction

    // Tag lookup for one access; a miss of either kind allocates the set.
    function automatic access_outcome_t lookup_and_allocate(
        input op_e         op,
        input logic [31:0] addr
    );
        access_outcome_t     o;
        logic [SET_BITS-1:0] set_idx;
        logic [TAG_BITS-1:0] tag;
        set_idx = addr[OFFSET_BITS +: SET_BITS];
        tag     = addr[ADDR_W-1 -: TAG_BITS];
        o.hit   = line_valid[set_idx] && (line_tag[set_idx] == tag);
        if (op == OP_WRITE)
        begin
            write_total = saturating_bump(write_total);
            if (o.hit)
            begin
                write_hit_total = saturating_bump(write_hit_total);
            end
        end
        else
        begin
            read_total = saturating_bump(read_total);
            if (o.hit)
            begin
                read_hit_total = saturating_bump(read_hit_total);
            end
        end
        if (!o.hit)
        begin
            line_valid[set_idx] = 1'b1;
            line_tag[set_idx]   = tag;
        end
        o.reads_seen      = read_total;
        o.read_hits_seen  = read_hit_total;
        o.writes_seen     = write_total;
        o.write_hits_seen = write_hit_total;
        return o;
    endfunction

    function automatic void note_mismatch(
        input string       field,
        input logic [31:0] want,
        input logic [31:0] got
    );
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%0t: result %0d %s mismatch: expected %h, got %h",
                     $realtime, outcomes_taken, field, want, got);
        end
    endfunction

    // Offer one access, idling first at random outside the steady window.
    // The expectation is queued at the edge the access is accepted.
    task automatic push_access(
        input op_e         op,
        input logic [31:0] addr,
        input logic        pinned,
        input logic        pinned_hit
    );
        access_outcome_t want;
        bit              steady;
        steady = (items_sent >= STEADY_FIRST) && (items_sent < STEADY_LAST);
        while (!steady && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            access_ch.valid <= 1'b0;
            @(posedge clk);
        end
        access_ch.valid     <= 1'b1;
        access_ch.operation <= op;
        access_ch.address   <= addr;
        do
        begin
            @(posedge clk);
        end
        while (access_ch.ready !== 1'b1);
        want = lookup_and_allocate(op, addr);
        if (pinned)
        begin
            want.hit = pinned_hit;
        end
        pending_outcomes.push_back(want);
        recent_addr[recent_ptr] = addr;
        recent_ptr = (recent_ptr + 1) % 8;
        items_sent++;
    endtask

    // ------------------------------------------------------------------
    // Long receiver hold-off: the sender keeps offering, so the pipe
    // fills and access.ready has to drop.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned hold_at [2];
        hold_at = '{HOLD_AT_A, HOLD_AT_B};
        foreach (hold_at[k])
        begin
            wait (outcomes_taken >= hold_at[k]);
            @(posedge clk);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result side: check each taken item, then pick the next ready value.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        access_outcome_t want;
        if ((result_ch.valid & result_ch.ready) === 1'b1)
        begin
            if (pending_outcomes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("%0t: result item with no access pending", $realtime);
                end
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (result_ch.hit !== want.hit)
                begin
                    note_mismatch("hit", 32'(want.hit), 32'(result_ch.hit));
                end
                if (result_ch.reads_seen !== want.reads_seen)
                begin
                    note_mismatch("reads_seen", want.reads_seen, result_ch.reads_seen);
                end
                if (result_ch.read_hits_seen !== want.read_hits_seen)
                begin
                    note_mismatch("read_hits_seen", want.read_hits_seen,
                                  result_ch.read_hits_seen);
                end
                if (result_ch.writes_seen !== want.writes_seen)
                begin
                    note_mismatch("writes_seen", want.writes_seen, result_ch.writes_seen);
                end
                if (result_ch.write_hits_seen !== want.write_hits_seen)
                begin
                    note_mismatch("write_hits_seen", want.write_hits_seen,
                                  result_ch.write_hits_seen);
                end
            end
            outcomes_taken++;
        end

        if (hold_on)
        begin
            result_ch.ready <= 1'b0;
        end
        else if ((outcomes_taken >= STEADY_FIRST) && (outcomes_taken < STEADY_LAST))
        begin
            result_ch.ready <= 1'b1;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if (((access_ch.valid & access_ch.ready) === 1'b1) ||
            ((result_ch.valid & result_ch.ready) === 1'b1))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[direct_mapped_cache_tag_checker_core] ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    probe_row_t probe_table [PROBE_COUNT] = '{
        // cold cache, then the same line again
        '{OP_READ,  32'h0000_0000, 1'b1, 1'b0},
        '{OP_READ,  32'h0000_0000, 1'b1, 1'b1},
        // last byte of that line: still the same tag
        '{OP_WRITE, 32'h0000_003F, 1'b1, 1'b1},
        '{OP_WRITE, 32'h0000_0040, 1'b1, 1'b0},
        // top set with an all-ones tag
        '{OP_READ,  32'hFFFF_FFFF, 1'b1, 1'b0},
        '{OP_WRITE, 32'hFFFF_FFC0, 1'b1, 1'b1},
        // tag zero in the top set evicts the all-ones tag
        '{OP_READ,  32'h0000_3FC0, 1'b1, 1'b0},
        '{OP_READ,  32'hFFFF_FFFF, 1'b1, 1'b0},
        // conflicting tags in set zero, then another tag in the top set
        '{OP_WRITE, 32'h0000_4000, 1'b1, 1'b0},
        '{OP_READ,  32'h0000_0000, 1'b1, 1'b0},
        '{OP_WRITE, 32'h8000_0000, 1'b1, 1'b0},
        '{OP_WRITE, 32'h8000_0000, 1'b1, 1'b1},
        '{OP_READ,  32'h7FFF_FFFF, 1'b1, 1'b0},
        // alternating bit patterns
        '{OP_READ,  32'h5555_5555, 1'b0, 1'b0},
        '{OP_WRITE, 32'hAAAA_AAAA, 1'b0, 1'b0},
        '{OP_READ,  32'h5555_5555, 1'b0, 1'b0},
        // swaps in one set: back-to-back ones exercise the same-set bypass
        '{OP_WRITE, 32'h0000_1000, 1'b1, 1'b0},
        '{OP_READ,  32'h0000_5000, 1'b1, 1'b0},
        '{OP_READ,  32'h0000_1000, 1'b1, 1'b0},
        '{OP_READ,  32'h0000_1004, 1'b1, 1'b1},
        '{OP_WRITE, 32'h0000_103F, 1'b1, 1'b1}
    };

    initial
    begin
        logic [TAG_BITS-1:0] tag_pool [4];
        logic [SET_BITS-1:0] hot_sets [16];
        logic [31:0]         addr;
        op_e                 op;
        int unsigned         pick;

        rst_n               = 1'b0;
        access_ch.valid     = 1'b0;
        access_ch.operation = OP_READ;
        access_ch.address   = '0;
        result_ch.ready     = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PROBE_COUNT; i++)
        begin
            push_access(probe_table[i].op, probe_table[i].addr,
                        probe_table[i].pinned, probe_table[i].hit);
        end

        // Random part: the largest share is a small working set of sets and
        // tags, so that hits, conflict misses and re-allocations keep coming;
        // the rest is reuse of recent lines and fully random addresses.
        foreach (tag_pool[i])
        begin
            tag_pool[i] = TAG_BITS'($urandom);
        end
        foreach (hot_sets[i])
        begin
            hot_sets[i] = SET_BITS'($urandom);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ((n % 150) == 149)
            begin
                tag_pool[$urandom_range(0, 3)] = TAG_BITS'($urandom);
                hot_sets[$urandom_range(0, 15)] = SET_BITS'($urandom);
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                addr = {tag_pool[$urandom_range(0, 3)], hot_sets[$urandom_range(0, 15)],
                        OFFSET_BITS'($urandom)};
            end
            else if (pick < 80)
            begin
                addr = {recent_addr[$urandom_range(0, 7)][31:OFFSET_BITS],
                        OFFSET_BITS'($urandom)};
            end
            else
            begin
                addr = $urandom;
            end
            op = op_e'($urandom_range(0, 1));
            push_access(op, addr, 1'b0, 1'b0);
        end
        access_ch.valid <= 1'b0;

        while (pending_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if ((mismatch_count == 0) && (pending_outcomes.size() == 0))
        begin
            $display("[direct_mapped_cache_tag_checker_core] OK");
        end
        else
        begin
            $display("[direct_mapped_cache_tag_checker_core] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/dmc_pkg.sv
rtl/core/dmc_access_if.sv
rtl/core/dmc_result_if.sv
rtl/core/dmc_index.sv
rtl/core/dmc_tag_store.sv
rtl/core/direct_mapped_cache_tag_checker_core.sv
rtl/core/dmc_checker.sv
verif/testbench.sv
